FILE: hw/rtl/bdar_pkg.sv
// Shared constants, register indexes and control types of the button debounce block.
package bdar_pkg;

   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;
   localparam int IDX_W  = 2;
   localparam int CNT_W  = $clog2(TIME_W);

   localparam logic [IDX_W-1:0] REG_ACTIVE_HIGH  = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS  = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_REPEAT_DELAY = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_REPEAT_EVERY = IDX_W'(3);

   localparam logic             RST_ACTIVE_HIGH  = 1'b1;
   localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS  = CFG_W'(50);
   localparam logic [CFG_W-1:0] RST_REPEAT_DELAY = CFG_W'(500);
   localparam logic [CFG_W-1:0] RST_REPEAT_EVERY = CFG_W'(100);

   typedef struct packed {
      logic load;
      logic eval;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } dp_status_type;

endpackage

FILE: hw/rtl/bdar_if.sv
// Handshake channel interfaces for poll requests and poll responses.
interface bdar_req_if import bdar_pkg::*;;
   logic              valid;
   logic              ready;
   logic              pin_level;
   logic [TIME_W-1:0] now_ms;
   logic              repeat_wanted;

   modport source (output valid, pin_level, now_ms, repeat_wanted, input ready);
   modport sink (input valid, pin_level, now_ms, repeat_wanted, output ready);
endinterface

interface bdar_rsp_if;
   logic valid;
   logic ready;
   logic press_event;
   logic held;

   modport source (output valid, press_event, held, input ready);
   modport sink (input valid, press_event, held, output ready);
endinterface

FILE: hw/rtl/bdar_div.sv
// Restoring serial divider giving one quotient bit per cycle.
module bdar_div import bdar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [CFG_W-1:0]  divisor,
   output logic [TIME_W-1:0] quotient,
   output logic              done
);

   logic [TIME_W-1:0] quo_ff;
   logic [CFG_W-1:0]  rem_ff;
   logic [CFG_W-1:0]  div_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CFG_W:0]    rem_sh;
   logic [CFG_W:0]    diff;
   logic              ge;

   assign rem_sh = {rem_ff, quo_ff[TIME_W-1]};
   assign diff   = rem_sh - {1'b0, div_ff};
   assign ge     = (rem_sh >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(TIME_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[TIME_W-2:0], ge};
         rem_ff <= ge ? diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

FILE: hw/rtl/bdar_dp.sv
// Datapath: configuration, debounce state, repeat bookkeeping and the response register.
module bdar_dp import bdar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  logic              pin_level,
   input  logic [TIME_W-1:0] now_ms,
   input  logic              repeat_wanted,
   output logic              press_event,
   output logic              held
);

   logic              act_high_ff;
   logic [CFG_W-1:0]  debounce_ff;
   logic [CFG_W-1:0]  delay_ff;
   logic [CFG_W-1:0]  every_ff;

   logic              pin_ff;
   logic [TIME_W-1:0] now_ff;
   logic              want_ff;

   logic              pressed_ff;
   logic              reported_ff;
   logic [TIME_W-1:0] press_start_ff;
   logic [TIME_W-1:0] hold_start_ff;
   logic [TIME_W-1:0] repeats_ff;
   logic              held_ff;
   logic              event_ff;
   logic              div_used_ff;
   logic              out_event_ff;
   logic              out_held_ff;

   logic              level;
   logic [TIME_W-1:0] elapsed;
   logic              held_in;
   logic [TIME_W-1:0] hold;
   logic [CFG_W:0]    delay_eff;
   logic [CFG_W-1:0]  every_eff;
   logic              need_div;
   logic              first_press;
   logic [TIME_W-1:0] span;
   logic [TIME_W-1:0] quotient;
   logic              div_done;
   logic              rep_hit;

   assign level       = (pin_ff == act_high_ff);
   assign elapsed     = now_ff - press_start_ff;
   assign held_in     = pressed_ff ? (level || (elapsed < TIME_W'(debounce_ff))) : level;
   assign hold        = now_ff - hold_start_ff;
   assign delay_eff   = (delay_ff < debounce_ff) ? {debounce_ff, 1'b1} : {1'b0, delay_ff};
   assign every_eff   = (every_ff == '0) ? CFG_W'(1) : every_ff;
   assign first_press = held_in && !reported_ff;
   assign need_div    = held_in && reported_ff && want_ff && (hold >= TIME_W'(delay_eff));
   assign span        = hold - TIME_W'(delay_eff);
   assign rep_hit     = div_used_ff && (quotient > repeats_ff);

   bdar_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.eval && need_div),
      .dividend (span),
      .divisor  (every_eff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.need_div = need_div;
   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_high_ff <= RST_ACTIVE_HIGH;
         debounce_ff <= RST_DEBOUNCE_MS;
         delay_ff    <= RST_REPEAT_DELAY;
         every_ff    <= RST_REPEAT_EVERY;
      end else if (csr_we) begin
         case (csr_index)
            REG_ACTIVE_HIGH:  act_high_ff <= csr_wdata[0];
            REG_DEBOUNCE_MS:  debounce_ff <= csr_wdata;
            REG_REPEAT_DELAY: delay_ff    <= csr_wdata;
            REG_REPEAT_EVERY: every_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pin_ff  <= pin_level;
         now_ff  <= now_ms;
         want_ff <= repeat_wanted;
      end
      if (cmd.emit) begin
         out_event_ff <= event_ff || rep_hit;
         out_held_ff  <= held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff     <= 1'b0;
         reported_ff    <= 1'b0;
         press_start_ff <= '0;
         hold_start_ff  <= '0;
         repeats_ff     <= '0;
         held_ff        <= 1'b0;
         event_ff       <= 1'b0;
         div_used_ff    <= 1'b0;
      end else if (cmd.eval) begin
         pressed_ff  <= held_in;
         held_ff     <= held_in;
         event_ff    <= first_press;
         div_used_ff <= need_div;
         if (!pressed_ff && level) begin
            press_start_ff <= now_ff;
         end
         if (!held_in) begin
            reported_ff <= 1'b0;
         end else if (!reported_ff) begin
            reported_ff   <= 1'b1;
            hold_start_ff <= now_ff;
            repeats_ff    <= '0;
         end
      end else if (cmd.emit && rep_hit) begin
         repeats_ff <= repeats_ff + TIME_W'(1);
      end
   end

   assign press_event = out_event_ff;
   assign held        = out_held_ff;

endmodule

FILE: hw/rtl/bdar_ctrl.sv
// Controller state machine sequencing each poll through evaluation, division when a repeat check is due, and response.
module bdar_ctrl import bdar_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load = (state_ff == ST_IDLE) && req_valid;
   assign cmd.eval = (state_ff == ST_EVAL);
   assign cmd.emit = (state_ff == ST_FINISH) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               state_ff <= status.need_div ? ST_DIV : ST_FINISH;
            end
            ST_DIV: begin
               if (status.div_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: hw/rtl/button_debounce_auto_repeat_top.sv
// Top level of the button debounce block with auto-repeat.
//
//   Channel   Direction  Payload
//   req       in         pin_level, now_ms, repeat_wanted
//   rsp       out        press_event, held
//   csr       in         csr_we, csr_index, csr_wdata
//
// A poll passes from transfer through evaluation to a valid response, and through the serial
// divider, which yields one quotient bit per cycle, when a repeat check is due.
// Reset is synchronous and restores the register defaults and the idle debounce state.
// A stalled response is held in its output register; the next poll is taken meanwhile,
// but its own response waits until that register is free.
module button_debounce_auto_repeat_top import bdar_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bdar_req_if.sink         req,
   bdar_rsp_if.source       rsp,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bdar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bdar_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status),
      .pin_level     (req.pin_level),
      .now_ms        (req.now_ms),
      .repeat_wanted (req.repeat_wanted),
      .press_event   (rsp.press_event),
      .held          (rsp.held)
   );

`ifndef SYNTH
   // A poll is evaluated before the next one can be taken.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("poll accepted in the cycle after a transfer");

   // A press event is only ever reported while the button is held.
   a_event_needs_held: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.press_event |-> rsp.held)
      else $error("press event reported without the button held");

   // An emitted response is presented in the following cycle.
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp.valid)
      else $error("emitted response not presented");
`endif

endmodule

FILE: dv/debounce_checker.sv
// Checker that predicts every debounced poll response and compares it with the block.
`timescale 1ns / 1ps
module debounce_checker import bdar_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bdar_req_if              req,
   bdar_rsp_if              rsp,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int               polls_open,
   output int               mismatches
);

   typedef struct packed {
      logic press_event;
      logic held;
   } poll_result_type;

   logic              high_means_pressed;
   logic [CFG_W-1:0]  debounce_ms;
   logic [CFG_W-1:0]  delay_ms;
   logic [CFG_W-1:0]  every_ms;
   logic              button_down;
   logic              press_seen;
   logic [TIME_W-1:0] press_time;
   logic [TIME_W-1:0] hold_time;
   logic [TIME_W-1:0] repeats;
   poll_result_type   due_results[$];
   int                miss_count = 0;

   assign mismatches = miss_count;

   task automatic debounce_poll(input logic pin, input logic [TIME_W-1:0] now,
                                input logic want_repeat, output poll_result_type res);
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] start_delay;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] steps;
      res = '0;
      elapsed = now - press_time;
      if (button_down) begin
         if (pin != high_means_pressed && elapsed >= TIME_W'(debounce_ms)) begin
            button_down = 1'b0;
         end
      end else if (pin == high_means_pressed) begin
         press_time  = now;
         button_down = 1'b1;
      end
      res.held = button_down;
      if (!button_down) begin
         press_seen = 1'b0;
      end else if (!press_seen) begin
         hold_time       = now;
         repeats         = '0;
         press_seen      = 1'b1;
         res.press_event = 1'b1;
      end else if (want_repeat) begin
         elapsed     = now - hold_time;
         start_delay = (delay_ms < debounce_ms) ?
                       (TIME_W'(debounce_ms) << 1) + TIME_W'(1) : TIME_W'(delay_ms);
         interval    = (every_ms == '0) ? TIME_W'(1) : TIME_W'(every_ms);
         if (elapsed >= start_delay) begin
            steps = (elapsed - start_delay) / interval;
            if (steps > repeats) begin
               repeats         = repeats + TIME_W'(1);
               res.press_event = 1'b1;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      poll_result_type want;
      poll_result_type got;
      if (reset) begin
         high_means_pressed = RST_ACTIVE_HIGH;
         debounce_ms        = RST_DEBOUNCE_MS;
         delay_ms           = RST_REPEAT_DELAY;
         every_ms           = RST_REPEAT_EVERY;
         button_down        = 1'b0;
         press_seen         = 1'b0;
         press_time         = '0;
         hold_time          = '0;
         repeats            = '0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ACTIVE_HIGH:  high_means_pressed = csr_wdata[0];
               REG_DEBOUNCE_MS:  debounce_ms = csr_wdata;
               REG_REPEAT_DELAY: delay_ms = csr_wdata;
               REG_REPEAT_EVERY: every_ms = csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            debounce_poll(req.pin_level, req.now_ms, req.repeat_wanted, want);
            due_results.push_back(want);
         end
         if (rsp.valid && rsp.ready) begin
            got.press_event = rsp.press_event;
            got.held        = rsp.held;
            if (due_results.size() == 0) begin
               if (miss_count < 10) begin
                  $display("%0t: response transfer with no poll outstanding: event %b held %b",
                           $time, got.press_event, got.held);
               end
               miss_count++;
            end else begin
               want = due_results.pop_front();
               if (got.press_event !== want.press_event || got.held !== want.held) begin
                  if (miss_count < 10) begin
                     $display({"%0t: poll response differs: expected event %b held %b, ",
                               "got event %b held %b"},
                              $time, want.press_event, want.held, got.press_event, got.held);
                  end
                  miss_count++;
               end
            end
         end
      end
      polls_open <= due_results.size();
   end

endmodule

FILE: dv/tb.sv
// Testbench top: clock, reset, poll and register stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
   import bdar_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_POLLS  = 170;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 40;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]  csr_wdata;
   logic              calm;
   int                polls_open;
   int                mismatches;
   int                polls_sent;
   int                quiet_cycles = 0;
   int                target;
   logic              pressed_level;
   logic [TIME_W-1:0] clock_ms;
   logic [TIME_W-1:0] max_step;

   bdar_req_if req_ch ();
   bdar_rsp_if rsp_ch ();

   button_debounce_auto_repeat_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   debounce_checker i_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .polls_open (polls_open),
      .mismatches (mismatches)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("button_debounce_auto_repeat_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_poll(input logic pin, input logic [TIME_W-1:0] now, input logic want);
      while (!calm && $urandom_range(99) < 24) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.pin_level     <= pin;
      req_ch.now_ms        <= now;
      req_ch.repeat_wanted <= want;
      do @(posedge clock); while (!req_ch.ready);
      polls_sent++;
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic high, input logic [CFG_W-1:0] db,
                           input logic [CFG_W-1:0] dl, input logic [CFG_W-1:0] ev);
      logic [TIME_W-1:0] start_delay;
      logic [TIME_W-1:0] interval;
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (polls_open != 0);
      write_reg(REG_ACTIVE_HIGH, CFG_W'(high));
      write_reg(REG_DEBOUNCE_MS, db);
      write_reg(REG_REPEAT_DELAY, dl);
      write_reg(REG_REPEAT_EVERY, ev);
      csr_we <= 1'b0;
      pressed_level = high;
      start_delay   = (dl < db) ? (TIME_W'(db) << 1) + TIME_W'(1) : TIME_W'(dl);
      interval      = (ev == '0) ? TIME_W'(1) : TIME_W'(ev);
      max_step      = (start_delay + TIME_W'(6) * interval) / TIME_W'(10) + TIME_W'(1);
   endtask

   task automatic press_session();
      int hold_polls;
      int release_polls;
      hold_polls    = $urandom_range(25, 2);
      release_polls = $urandom_range(4, 1);
      clock_ms += $urandom_range(max_step, 1);
      send_poll(pressed_level, clock_ms, 1'b1);
      for (int i = 0; i < hold_polls; i++) begin
         clock_ms += $urandom_range(max_step, 1);
         send_poll(($urandom_range(9) == 0) ? !pressed_level : pressed_level, clock_ms,
                   $urandom_range(7) != 0);
      end
      if ($urandom_range(4) != 0) begin
         for (int i = 0; i < release_polls; i++) begin
            clock_ms += $urandom_range(max_step, 1);
            send_poll(!pressed_level, clock_ms, 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic noise_poll();
      if ($urandom_range(1) != 0) begin
         clock_ms = $urandom();
      end else begin
         clock_ms -= $urandom_range(max_step, 1);
      end
      send_poll(1'($urandom_range(1)), clock_ms, 1'($urandom_range(1)));
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.pin_level     = 1'b0;
      req_ch.now_ms        = '0;
      req_ch.repeat_wanted = 1'b0;
      calm                 = 1'b0;
      polls_sent           = 0;
      pressed_level        = RST_ACTIVE_HIGH;
      max_step             = TIME_W'(111);
      clock_ms             = $urandom();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_poll(1'b0, 32'hFFFF_FFF0, 1'b0);
      send_poll(1'b1, 32'hFFFF_FFF1, 1'b1);
      send_poll(1'b0, 32'hFFFF_FFFA, 1'b1);
      send_poll(1'b1, 32'h0000_0250, 1'b1);
      send_poll(1'b1, 32'h0000_0318, 1'b1);
      send_poll(1'b1, 32'h0000_0319, 1'b1);
      send_poll(1'b1, 32'h0000_031A, 1'b1);
      send_poll(1'b1, 32'h0000_031B, 1'b1);
      send_poll(1'b1, 32'h0000_07C0, 1'b0);
      send_poll(1'b0, 32'h0000_07C1, 1'b0);
      send_poll(1'b0, 32'h0000_07B6, 1'b1);
      send_poll(1'b1, 32'h0000_0000, 1'b1);
      send_poll(1'b0, 32'hFFFF_FFFF, 1'b0);
      send_poll(1'b1, 32'h0000_0005, 1'b1);
      send_poll(1'b1, 32'h0000_0004, 1'b1);
      send_poll(1'b1, 32'h0000_0003, 1'b1);
      send_poll(1'b0, 32'h0000_0064, 1'b0);
      send_poll(1'b0, 32'h0001_86A0, 1'b1);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: set_regs(1'b0, 16'd20, 16'd100, 16'd0);
            1: set_regs(1'b1, 16'd200, 16'd50, 16'd30);
            2: set_regs(1'b1, 16'd0, 16'd0, 16'd1);
            3: set_regs(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            4: set_regs(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
            default: set_regs(1'($urandom_range(1)), CFG_W'($urandom_range(300)),
                              CFG_W'($urandom_range(2000)), CFG_W'($urandom_range(200)));
         endcase
         calm   <= (ph == 5);
         target = polls_sent + PHASE_POLLS;
         while (polls_sent < target) begin
            if ($urandom_range(99) < 80) begin
               press_session();
            end else begin
               noise_poll();
            end
         end
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (polls_open != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("button_debounce_auto_repeat_top: match");
      end else begin
         $display("button_debounce_auto_repeat_top: mismatch");
      end
      $finish;
   end

endmodule
